// File: rtl/wid_pkg.sv
// Package for the WebAssembly instruction decoder: phase codes, immediate kinds,
// error codes, result struct and the opcode decode table.
// No dependencies.
package wid_pkg;

  localparam int OFFSET_BITS = 32;

  localparam logic [3:0] PH_IDLE  = 4'd0;
  localparam logic [3:0] PH_SUB   = 4'd1;
  localparam logic [3:0] PH_U1    = 4'd2;
  localparam logic [3:0] PH_U2    = 4'd3;
  localparam logic [3:0] PH_I32   = 4'd4;
  localparam logic [3:0] PH_I64   = 4'd5;
  localparam logic [3:0] PH_BLK   = 4'd6;
  localparam logic [3:0] PH_S33   = 4'd7;
  localparam logic [3:0] PH_RSV   = 4'd8;
  localparam logic [3:0] PH_BYTES = 4'd9;
  localparam logic [3:0] PH_VCNT  = 4'd10;
  localparam logic [3:0] PH_BCNT  = 4'd11;
  localparam logic [3:0] PH_BLAB  = 4'd12;

  localparam logic [3:0] KIND_NONE  = 4'd0;
  localparam logic [3:0] KIND_U32   = 4'd1;
  localparam logic [3:0] KIND_PAIR  = 4'd2;
  localparam logic [3:0] KIND_MEM   = 4'd3;
  localparam logic [3:0] KIND_I32   = 4'd4;
  localparam logic [3:0] KIND_I64   = 4'd5;
  localparam logic [3:0] KIND_BLOCK = 4'd6;
  localparam logic [3:0] KIND_BYTES = 4'd7;
  localparam logic [3:0] KIND_TABLE = 4'd8;

  localparam logic [1:0] CLS_EMPTY = 2'd0;
  localparam logic [1:0] CLS_VALUE = 2'd1;
  localparam logic [1:0] CLS_INDEX = 2'd2;

  localparam logic [1:0] ERR_NONE     = 2'd0;
  localparam logic [1:0] ERR_OPCODE   = 2'd1;
  localparam logic [1:0] ERR_RESERVED = 2'd2;
  localparam logic [1:0] ERR_OVERLONG = 2'd3;

  localparam logic [7:0] OP_EMPTY_BT  = 8'h40;
  localparam logic [7:0] OP_MISC      = 8'hFC;
  localparam logic [7:0] OP_SIMD      = 8'hFD;
  localparam logic [7:0] OP_JUMP_TBL  = 8'h0E;
  localparam logic [7:0] OP_SEL_TYPED = 8'h1C;
  localparam logic [7:0] OP_F32       = 8'h43;
  localparam logic [7:0] OP_F64       = 8'h44;
  localparam logic [7:0] OP_CALL_IND  = 8'h11;
  localparam logic [7:0] OP_BLK_LO    = 8'h02;
  localparam logic [7:0] VT_I32       = 8'h7F;
  localparam logic [7:0] VT_EXTERN    = 8'h6F;

  typedef struct packed {
    logic [3:0] kind;
    logic [1:0] rsv;
    logic [4:0] fixed;
    logic       ok;
  } plan_t;

  typedef struct packed {
    logic [7:0]  opcode;
    logic [7:0]  subopcode;
    logic [3:0]  imm_kind;
    logic [1:0]  block_class;
    logic [63:0] imm_first;
    logic [31:0] imm_second;
    logic [31:0] data_offset;
    logic [31:0] data_length;
    logic [31:0] start_offset;
    logic [1:0]  error;
  } res_t;

  function automatic plan_t mk(logic [3:0] kind, logic [1:0] rsv, logic [4:0] fixed,
                               logic ok);
    plan_t p;
    p.kind = kind;
    p.rsv = rsv;
    p.fixed = fixed;
    p.ok = ok;
    return p;
  endfunction

  function automatic logic fd_plain(logic [7:0] s);
    return (s >= 8'd14 && s <= 8'd83) || (s >= 8'd94 && s <= 8'd153) ||
           (s >= 8'd155 && s <= 8'd161) || s == 8'd163 || s == 8'd164 ||
           (s >= 8'd167 && s <= 8'd174) || s == 8'd177 || (s >= 8'd181 && s <= 8'd186) ||
           (s >= 8'd188 && s <= 8'd193) || s == 8'd195 || s == 8'd196 ||
           (s >= 8'd199 && s <= 8'd206) || s == 8'd209 || (s >= 8'd213 && s <= 8'd225) ||
           (s >= 8'd227 && s <= 8'd237) || s >= 8'd239;
  endfunction

  function automatic plan_t plan_of(logic [7:0] op, logic [7:0] sub);
    plan_t p;
    p = mk(KIND_NONE, 2'd0, 5'd0, 1'b0);
    if (op == OP_MISC) begin
      if (sub <= 8'd7) p = mk(KIND_NONE, 2'd0, 5'd0, 1'b1);
      else if (sub == 8'd8) p = mk(KIND_U32, 2'd1, 5'd0, 1'b1);
      else if (sub == 8'd9 || sub == 8'd13 || (sub >= 8'd15 && sub <= 8'd17))
        p = mk(KIND_U32, 2'd0, 5'd0, 1'b1);
      else if (sub == 8'd10) p = mk(KIND_NONE, 2'd2, 5'd0, 1'b1);
      else if (sub == 8'd11) p = mk(KIND_NONE, 2'd1, 5'd0, 1'b1);
      else if (sub == 8'd12 || sub == 8'd14) p = mk(KIND_PAIR, 2'd0, 5'd0, 1'b1);
    end else if (op == OP_SIMD) begin
      if (sub <= 8'd11 || sub == 8'd92 || sub == 8'd93) p = mk(KIND_MEM, 2'd0, 5'd0, 1'b1);
      else if (sub >= 8'd84 && sub <= 8'd91) p = mk(KIND_PAIR, 2'd0, 5'd0, 1'b1);
      else if (sub == 8'd12 || sub == 8'd13) p = mk(KIND_BYTES, 2'd0, 5'd16, 1'b1);
      else if (sub >= 8'd21 && sub <= 8'd34) p = mk(KIND_U32, 2'd0, 5'd0, 1'b1);
      else if (fd_plain(sub)) p = mk(KIND_NONE, 2'd0, 5'd0, 1'b1);
    end else if (op <= 8'h01 || op == 8'h05 || op == 8'h0B || op == 8'h0F || op == 8'h1A ||
                 op == 8'h1B || (op >= 8'h45 && op <= 8'hC4)) begin
      p = mk(KIND_NONE, 2'd0, 5'd0, 1'b1);
    end else if (op == 8'h3F || op == 8'h40) begin
      p = mk(KIND_NONE, 2'd1, 5'd0, 1'b1);
    end else if (op >= 8'h28 && op <= 8'h3E) begin
      p = mk(KIND_MEM, 2'd0, 5'd0, 1'b1);
    end else if (op == 8'h0C || op == 8'h0D || op == 8'h10 || (op >= 8'h20 && op <= 8'h26)) begin
      p = mk(KIND_U32, 2'd0, 5'd0, 1'b1);
    end else if (op == OP_CALL_IND) begin
      p = mk(KIND_PAIR, 2'd0, 5'd0, 1'b1);
    end else if (op >= OP_BLK_LO && op <= 8'h04) begin
      p = mk(KIND_BLOCK, 2'd0, 5'd0, 1'b1);
    end else if (op == OP_JUMP_TBL) begin
      p = mk(KIND_TABLE, 2'd0, 5'd0, 1'b1);
    end else if (op == OP_SEL_TYPED) begin
      p = mk(KIND_BYTES, 2'd0, 5'd0, 1'b1);
    end else if (op == 8'h41) begin
      p = mk(KIND_I32, 2'd0, 5'd0, 1'b1);
    end else if (op == 8'h42) begin
      p = mk(KIND_I64, 2'd0, 5'd0, 1'b1);
    end else if (op == OP_F32) begin
      p = mk(KIND_BYTES, 2'd0, 5'd4, 1'b1);
    end else if (op == OP_F64) begin
      p = mk(KIND_BYTES, 2'd0, 5'd8, 1'b1);
    end
    return p;
  endfunction

endpackage

// File: rtl/wid_parser.sv
// Byte-per-cycle parser (steps on fire): phase register, LEB accumulator, decode step.
// Depends on wid_pkg.
module wid_parser (
  input  logic             clk,
  input  logic             rst,
  input  logic             fire,
  input  logic [7:0]       code_byte,
  input  logic             restart,
  output logic             res_valid,
  output wid_pkg::res_t    res
);

  localparam int OB = wid_pkg::OFFSET_BITS;

  logic [3:0]    phase, phase_next;
  logic [7:0]    held_opcode, held_opcode_next;
  logic [7:0]    held_subop, held_subop_next;
  logic [63:0]   leb_accum, leb_accum_next;
  logic [3:0]    leb_cnt, leb_cnt_next;
  logic [31:0]   first_value, first_value_next;
  logic [31:0]   second_value, second_value_next;
  logic [31:0]   skip_remaining, skip_remaining_next;
  logic [31:0]   labels_remaining, labels_remaining_next;
  logic [OB-1:0] offset, offset_next;
  logic [OB-1:0] instr_start, instr_start_next;

  always_comb begin
    logic [3:0]    ph;
    logic [OB-1:0] cur, cur_inc;
    logic [6:0]    sh, sh2;
    logic [63:0]   acc_f;
    logic [3:0]    cnt_f;
    logic          sgn, done, long_leb, do_begin, emit;
    logic [3:0]    maxb;
    wid_pkg::plan_t p, pb;
    logic [3:0]    e_kind;
    logic [1:0]    e_cls, e_err;
    logic [63:0]   e_first;
    logic [31:0]   e_second, e_doff, e_dlen, dec;

    ph = restart ? wid_pkg::PH_IDLE : phase;
    cur = restart ? '0 : offset;
    cur_inc = cur + 1'b1;

    phase_next = phase;
    held_opcode_next = held_opcode;
    held_subop_next = held_subop;
    leb_accum_next = leb_accum;
    leb_cnt_next = leb_cnt;
    first_value_next = first_value;
    second_value_next = second_value;
    skip_remaining_next = skip_remaining;
    labels_remaining_next = labels_remaining;
    instr_start_next = instr_start;
    offset_next = cur_inc;

    sgn = (ph == wid_pkg::PH_I32) || (ph == wid_pkg::PH_I64) ||
          (ph == wid_pkg::PH_BLK) || (ph == wid_pkg::PH_S33);
    maxb = (ph == wid_pkg::PH_I64) ? 4'd10 : 4'd5;
    sh = {leb_cnt, 3'b000} - {3'b000, leb_cnt};
    cnt_f = leb_cnt + 1'b1;
    sh2 = {cnt_f, 3'b000} - {3'b000, cnt_f};
    acc_f = leb_accum | (64'(code_byte[6:0]) << sh);
    done = !code_byte[7];
    long_leb = code_byte[7] && (cnt_f >= maxb);
    if (done && sgn && code_byte[6]) acc_f = acc_f | (~64'd0 << sh2);

    p = wid_pkg::plan_of(held_opcode, held_subop);
    pb = p;
    do_begin = 1'b0;
    emit = 1'b0;
    e_kind = wid_pkg::KIND_NONE;
    e_cls = wid_pkg::CLS_EMPTY;
    e_err = wid_pkg::ERR_NONE;
    e_first = '0;
    e_second = '0;
    e_doff = '0;
    e_dlen = '0;
    dec = acc_f[31:0];

    case (ph)
      wid_pkg::PH_SUB: begin
        leb_accum_next = acc_f;
        leb_cnt_next = cnt_f;
        if (!code_byte[7] || long_leb) begin
          held_subop_next = acc_f[7:0];
          if (long_leb) begin
            emit = 1'b1;
            e_err = wid_pkg::ERR_OVERLONG;
          end else begin
            pb = wid_pkg::plan_of(held_opcode, acc_f[7:0]);
            if (!pb.ok || acc_f[31:8] != 24'd0) begin
              emit = 1'b1;
              e_err = wid_pkg::ERR_OPCODE;
            end else begin
              do_begin = 1'b1;
            end
          end
        end
      end
      wid_pkg::PH_U1, wid_pkg::PH_U2, wid_pkg::PH_I32, wid_pkg::PH_I64, wid_pkg::PH_S33,
      wid_pkg::PH_VCNT, wid_pkg::PH_BCNT, wid_pkg::PH_BLAB: begin
        leb_accum_next = acc_f;
        leb_cnt_next = cnt_f;
        if (long_leb) begin
          emit = 1'b1;
          e_err = wid_pkg::ERR_OVERLONG;
        end else if (done) begin
          case (ph)
            wid_pkg::PH_U1: begin
              first_value_next = dec;
              if (p.kind == wid_pkg::KIND_PAIR || p.kind == wid_pkg::KIND_MEM) begin
                leb_accum_next = '0;
                leb_cnt_next = '0;
                phase_next = wid_pkg::PH_U2;
              end else if (p.rsv != 2'd0) begin
                skip_remaining_next = 32'(p.rsv);
                phase_next = wid_pkg::PH_RSV;
              end else begin
                emit = 1'b1;
                e_kind = wid_pkg::KIND_U32;
                e_first = 64'(dec);
              end
            end
            wid_pkg::PH_U2: begin
              emit = 1'b1;
              e_kind = p.kind;
              e_first = 64'(first_value);
              e_second = dec;
            end
            wid_pkg::PH_I32: begin
              emit = 1'b1;
              e_kind = wid_pkg::KIND_I32;
              e_first = {{32{dec[31]}}, dec};
            end
            wid_pkg::PH_I64: begin
              emit = 1'b1;
              e_kind = wid_pkg::KIND_I64;
              e_first = acc_f;
            end
            wid_pkg::PH_S33: begin
              emit = 1'b1;
              e_kind = wid_pkg::KIND_BLOCK;
              e_cls = wid_pkg::CLS_INDEX;
              e_first = {{31{acc_f[32]}}, acc_f[32:0]};
            end
            wid_pkg::PH_VCNT: begin
              first_value_next = 32'(cur_inc);
              second_value_next = dec;
              if (dec == 32'd0) begin
                emit = 1'b1;
                e_kind = wid_pkg::KIND_BYTES;
                e_doff = 32'(cur_inc);
              end else begin
                skip_remaining_next = dec;
                phase_next = wid_pkg::PH_BYTES;
              end
            end
            wid_pkg::PH_BCNT: begin
              labels_remaining_next = dec;
              second_value_next = (dec == 32'hFFFF_FFFF) ? dec : dec + 32'd1;
              first_value_next = 32'(cur_inc);
              leb_accum_next = '0;
              leb_cnt_next = '0;
              phase_next = wid_pkg::PH_BLAB;
            end
            default: begin
              if (labels_remaining == 32'd0) begin
                emit = 1'b1;
                e_kind = wid_pkg::KIND_TABLE;
                e_doff = first_value;
                e_dlen = second_value;
              end else begin
                labels_remaining_next = labels_remaining - 32'd1;
                leb_accum_next = '0;
                leb_cnt_next = '0;
              end
            end
          endcase
        end
      end
      wid_pkg::PH_BLK: begin
        if (code_byte == wid_pkg::OP_EMPTY_BT) begin
          emit = 1'b1;
          e_kind = wid_pkg::KIND_BLOCK;
        end else if ((code_byte >= 8'h7B && code_byte <= wid_pkg::VT_I32) ||
                     code_byte == 8'h70 || code_byte == wid_pkg::VT_EXTERN) begin
          emit = 1'b1;
          e_kind = wid_pkg::KIND_BLOCK;
          e_cls = wid_pkg::CLS_VALUE;
          e_first = 64'(code_byte);
        end else begin
          leb_accum_next = acc_f;
          leb_cnt_next = cnt_f;
          if (done) begin
            emit = 1'b1;
            e_kind = wid_pkg::KIND_BLOCK;
            e_cls = wid_pkg::CLS_INDEX;
            e_first = {{31{acc_f[32]}}, acc_f[32:0]};
          end else begin
            phase_next = wid_pkg::PH_S33;
          end
        end
      end
      wid_pkg::PH_RSV: begin
        skip_remaining_next = skip_remaining - 32'd1;
        if (code_byte != 8'd0) begin
          emit = 1'b1;
          e_err = wid_pkg::ERR_RESERVED;
        end else if (skip_remaining == 32'd1) begin
          emit = 1'b1;
          e_kind = p.kind;
          e_first = 64'(first_value);
        end
      end
      wid_pkg::PH_BYTES: begin
        skip_remaining_next = skip_remaining - 32'd1;
        if (skip_remaining == 32'd1) begin
          emit = 1'b1;
          e_kind = wid_pkg::KIND_BYTES;
          e_doff = first_value;
          e_dlen = second_value;
        end
      end
      default: begin
        instr_start_next = cur;
        held_opcode_next = code_byte;
        held_subop_next = 8'd0;
        if (code_byte == wid_pkg::OP_MISC || code_byte == wid_pkg::OP_SIMD) begin
          leb_accum_next = '0;
          leb_cnt_next = '0;
          phase_next = wid_pkg::PH_SUB;
        end else begin
          pb = wid_pkg::plan_of(code_byte, 8'd0);
          if (!pb.ok) begin
            emit = 1'b1;
            e_err = wid_pkg::ERR_OPCODE;
          end else begin
            do_begin = 1'b1;
          end
        end
      end
    endcase

    if (do_begin) begin
      leb_accum_next = '0;
      leb_cnt_next = '0;
      first_value_next = '0;
      second_value_next = '0;
      case (pb.kind)
        wid_pkg::KIND_NONE: begin
          if (pb.rsv != 2'd0) begin
            skip_remaining_next = 32'(pb.rsv);
            phase_next = wid_pkg::PH_RSV;
          end else begin
            emit = 1'b1;
          end
        end
        wid_pkg::KIND_U32, wid_pkg::KIND_PAIR, wid_pkg::KIND_MEM: phase_next = wid_pkg::PH_U1;
        wid_pkg::KIND_I32:   phase_next = wid_pkg::PH_I32;
        wid_pkg::KIND_I64:   phase_next = wid_pkg::PH_I64;
        wid_pkg::KIND_BLOCK: phase_next = wid_pkg::PH_BLK;
        wid_pkg::KIND_BYTES: begin
          if (pb.fixed != 5'd0) begin
            first_value_next = 32'(cur_inc);
            second_value_next = 32'(pb.fixed);
            skip_remaining_next = 32'(pb.fixed);
            phase_next = wid_pkg::PH_BYTES;
          end else begin
            phase_next = wid_pkg::PH_VCNT;
          end
        end
        default: phase_next = wid_pkg::PH_BCNT;
      endcase
    end

    if (emit) phase_next = wid_pkg::PH_IDLE;

    res_valid = emit;
    res.opcode = held_opcode_next;
    res.subopcode = held_subop_next;
    res.imm_kind = e_kind;
    res.block_class = e_cls;
    res.imm_first = e_first;
    res.imm_second = e_second;
    res.data_offset = e_doff;
    res.data_length = e_dlen;
    res.start_offset = 32'(instr_start_next);
    res.error = e_err;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= wid_pkg::PH_IDLE;
      held_opcode <= '0;
      held_subop <= '0;
      leb_accum <= '0;
      leb_cnt <= '0;
      first_value <= '0;
      second_value <= '0;
      skip_remaining <= '0;
      labels_remaining <= '0;
      offset <= '0;
      instr_start <= '0;
    end else if (fire) begin
      phase <= phase_next;
      held_opcode <= held_opcode_next;
      held_subop <= held_subop_next;
      leb_accum <= leb_accum_next;
      leb_cnt <= leb_cnt_next;
      first_value <= first_value_next;
      second_value <= second_value_next;
      skip_remaining <= skip_remaining_next;
      labels_remaining <= labels_remaining_next;
      offset <= offset_next;
      instr_start <= instr_start_next;
    end
  end

`ifndef SYNTHESIS
  a_emit_idle: assert property (@(posedge clk) disable iff (rst)
    fire && res_valid |=> phase == wid_pkg::PH_IDLE)
    else $error("parser not idle after result");
  a_offset_step: assert property (@(posedge clk) disable iff (rst)
    fire && !restart |=> offset == $past(offset) + 1'b1)
    else $error("offset did not advance");
  a_err_clean: assert property (@(posedge clk) disable iff (rst)
    fire && res_valid && res.error != wid_pkg::ERR_NONE |->
      res.imm_kind == wid_pkg::KIND_NONE && res.imm_first == 64'd0)
    else $error("error result carries immediates");
  a_class_kind: assert property (@(posedge clk) disable iff (rst)
    fire && res_valid && res.block_class != wid_pkg::CLS_EMPTY |->
      res.imm_kind == wid_pkg::KIND_BLOCK)
    else $error("block class without blocktype");
`endif

endmodule

// File: rtl/wid_out_reg.sv
// Result register for the decoder: holds one item until the consumer takes it.
// Depends on wid_pkg.
module wid_out_reg (
  input  logic          clk,
  input  logic          rst,
  input  logic          fire,
  input  logic          res_valid,
  input  wid_pkg::res_t res,
  input  logic          out_stall,
  output logic          ready,
  output logic          out_valid,
  output wid_pkg::res_t held
);

  assign ready = !out_valid || !out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (ready) begin
      out_valid <= fire && res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (ready && fire && res_valid) held <= res;
  end

endmodule

// File: rtl/wasm_instruction_decoder_unit.sv
// Top level of the WebAssembly instruction decoder: input register, parser, result register.
// Depends on wid_pkg, wid_parser and wid_out_reg.
//
//  channel | signals                          | direction
//  input   | in_valid, in_stall, code_byte,   | one code byte per item
//          | restart                          |
//  output  | out_valid, out_stall, opcode ... | one decoded instruction per item
//
// One byte is taken per cycle while in_stall is low; each byte passes through the input register,
// and the parser step, when it emits a result, writes it into the result register.
// Reset clears both valid flags and the parser.
// A stalled output holds the result and backs up into the input register, then in_stall.
module wasm_instruction_decoder_unit (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  code_byte,
  input  logic        restart,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [7:0]  opcode,
  output logic [7:0]  subopcode,
  output logic [3:0]  imm_kind,
  output logic [1:0]  block_class,
  output logic signed [63:0] imm_first,
  output logic [31:0] imm_second,
  output logic [31:0] data_offset,
  output logic [31:0] data_length,
  output logic [31:0] start_offset,
  output logic [1:0]  error
);

  logic          in_reg_valid;
  logic [7:0]    in_reg_byte;
  logic          in_reg_restart;
  logic          ready, fire, res_valid;
  wid_pkg::res_t res, held;

  assign fire = in_reg_valid && ready;
  assign in_stall = in_reg_valid && !ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_reg_valid <= 1'b0;
    end else if (!in_stall) begin
      in_reg_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!in_stall && in_valid) begin
      in_reg_byte <= code_byte;
      in_reg_restart <= restart;
    end
  end

  wid_parser u_parser (
    .clk(clk), .rst(rst), .fire(fire), .code_byte(in_reg_byte),
    .restart(in_reg_restart), .res_valid(res_valid), .res(res)
  );

  wid_out_reg u_out (
    .clk(clk), .rst(rst), .fire(fire), .res_valid(res_valid), .res(res),
    .out_stall(out_stall), .ready(ready), .out_valid(out_valid), .held(held)
  );

  assign opcode = held.opcode;
  assign subopcode = held.subopcode;
  assign imm_kind = held.imm_kind;
  assign block_class = held.block_class;
  assign imm_first = held.imm_first;
  assign imm_second = held.imm_second;
  assign data_offset = held.data_offset;
  assign data_length = held.data_length;
  assign start_offset = held.start_offset;
  assign error = held.error;

endmodule

// File: tb/wid_checker.sv
// Checker for the WebAssembly instruction decoder: follows the byte and result channels,
// predicts each decoded instruction and compares it with the block's result.
// Depends on wid_pkg.
module wid_checker
  import wid_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  input  logic        in_stall,
  input  logic [7:0]  code_byte,
  input  logic        restart,
  input  logic        out_valid,
  input  logic        out_stall,
  input  logic [7:0]  opcode,
  input  logic [7:0]  subopcode,
  input  logic [3:0]  imm_kind,
  input  logic [1:0]  block_class,
  input  logic [63:0] imm_first,
  input  logic [31:0] imm_second,
  input  logic [31:0] data_offset,
  input  logic [31:0] data_length,
  input  logic [31:0] start_offset,
  input  logic [1:0]  error,
  output int          fails,
  output int          pending
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int LEB_MORE = 0;
  localparam int LEB_DONE = 1;
  localparam int LEB_LONG = 2;

  typedef struct {
    logic [3:0] kind;
    logic [1:0] rsv;
    logic [4:0] fixed;
    bit         ok;
  } layout_t;

  typedef struct {
    logic [7:0]  opcode;
    logic [7:0]  subopcode;
    logic [3:0]  imm_kind;
    logic [1:0]  block_class;
    logic [63:0] imm_first;
    logic [31:0] imm_second;
    logic [31:0] data_offset;
    logic [31:0] data_length;
    logic [31:0] start_offset;
    logic [1:0]  error;
  } instr_t;

  instr_t      decoded_q[$];
  logic [3:0]  ph;
  logic [7:0]  cur_op;
  logic [7:0]  cur_sub;
  logic [63:0] acc;
  logic [3:0]  nbytes;
  logic [63:0] fval;
  logic [31:0] sval;
  logic [31:0] skip;
  logic [31:0] labels;
  logic [31:0] offs;
  logic [31:0] istart;

  function automatic layout_t lay(logic [3:0] k, logic [1:0] r, logic [4:0] f, bit ok);
    layout_t l;
    l.kind = k;
    l.rsv = r;
    l.fixed = f;
    l.ok = ok;
    return l;
  endfunction

  function automatic bit simd_bare(logic [31:0] s);
    return (s >= 14 && s <= 83) || (s >= 94 && s <= 153) || (s >= 155 && s <= 161) ||
           s == 163 || s == 164 || (s >= 167 && s <= 174) || s == 177 ||
           (s >= 181 && s <= 186) || (s >= 188 && s <= 193) || s == 195 || s == 196 ||
           (s >= 199 && s <= 206) || s == 209 || (s >= 213 && s <= 225) ||
           (s >= 227 && s <= 237) || (s >= 239 && s <= 255);
  endfunction

  function automatic layout_t layout_of(logic [7:0] op, logic [31:0] sub);
    if (op == OP_MISC) begin
      if (sub <= 7) return lay(KIND_NONE, 0, 0, 1);
      if (sub == 8) return lay(KIND_U32, 1, 0, 1);
      if (sub == 9 || sub == 13 || (sub >= 15 && sub <= 17)) return lay(KIND_U32, 0, 0, 1);
      if (sub == 10) return lay(KIND_NONE, 2, 0, 1);
      if (sub == 11) return lay(KIND_NONE, 1, 0, 1);
      if (sub == 12 || sub == 14) return lay(KIND_PAIR, 0, 0, 1);
      return lay(KIND_NONE, 0, 0, 0);
    end
    if (op == OP_SIMD) begin
      if (sub <= 11 || sub == 92 || sub == 93) return lay(KIND_MEM, 0, 0, 1);
      if (sub >= 84 && sub <= 91) return lay(KIND_PAIR, 0, 0, 1);
      if (sub == 12 || sub == 13) return lay(KIND_BYTES, 0, 16, 1);
      if (sub >= 21 && sub <= 34) return lay(KIND_U32, 0, 0, 1);
      if (simd_bare(sub)) return lay(KIND_NONE, 0, 0, 1);
      return lay(KIND_NONE, 0, 0, 0);
    end
    if (op <= 8'h01 || op == 8'h05 || op == 8'h0B || op == 8'h0F || op == 8'h1A ||
        op == 8'h1B || (op >= 8'h45 && op <= 8'hC4)) return lay(KIND_NONE, 0, 0, 1);
    if (op == 8'h3F || op == 8'h40) return lay(KIND_NONE, 1, 0, 1);
    if (op >= 8'h28 && op <= 8'h3E) return lay(KIND_MEM, 0, 0, 1);
    if (op == 8'h0C || op == 8'h0D || op == 8'h10 || (op >= 8'h20 && op <= 8'h26))
      return lay(KIND_U32, 0, 0, 1);
    if (op == OP_CALL_IND) return lay(KIND_PAIR, 0, 0, 1);
    if (op >= 8'h02 && op <= 8'h04) return lay(KIND_BLOCK, 0, 0, 1);
    if (op == OP_JUMP_TBL) return lay(KIND_TABLE, 0, 0, 1);
    if (op == OP_SEL_TYPED) return lay(KIND_BYTES, 0, 0, 1);
    if (op == 8'h41) return lay(KIND_I32, 0, 0, 1);
    if (op == 8'h42) return lay(KIND_I64, 0, 0, 1);
    if (op == OP_F32) return lay(KIND_BYTES, 0, 4, 1);
    if (op == OP_F64) return lay(KIND_BYTES, 0, 8, 1);
    return lay(KIND_NONE, 0, 0, 0);
  endfunction

  function automatic void post(logic [3:0] k, logic [1:0] c, logic [63:0] f, logic [31:0] s,
                               logic [31:0] doff, logic [31:0] dlen, logic [1:0] e);
    instr_t x;
    x.opcode = cur_op;
    x.subopcode = cur_sub;
    x.imm_kind = k;
    x.block_class = c;
    x.imm_first = f;
    x.imm_second = s;
    x.data_offset = doff;
    x.data_length = dlen;
    x.start_offset = istart;
    x.error = e;
    decoded_q.push_back(x);
    ph = PH_IDLE;
  endfunction

  function automatic void abort(logic [1:0] e);
    post(KIND_NONE, CLS_EMPTY, 0, 0, 0, 0, e);
  endfunction

  function automatic int leb_take(logic [7:0] b, int maxb, bit sgn);
    int sh;
    sh = 7 * nbytes;
    if (sh < 64) acc |= {57'd0, b[6:0]} << sh;
    nbytes = nbytes + 4'd1;
    if (b[7]) return (nbytes >= maxb) ? LEB_LONG : LEB_MORE;
    sh = 7 * nbytes;
    if (sgn && b[6] && sh < 64) acc |= ~64'd0 << sh;
    return LEB_DONE;
  endfunction

  function automatic void start_imm(logic [31:0] cur, layout_t l);
    acc = 0;
    nbytes = 0;
    fval = 0;
    sval = 0;
    case (l.kind)
      KIND_NONE: begin
        if (l.rsv != 0) begin
          skip = l.rsv;
          ph = PH_RSV;
        end else post(KIND_NONE, CLS_EMPTY, 0, 0, 0, 0, ERR_NONE);
      end
      KIND_U32, KIND_PAIR, KIND_MEM: ph = PH_U1;
      KIND_I32: ph = PH_I32;
      KIND_I64: ph = PH_I64;
      KIND_BLOCK: ph = PH_BLK;
      KIND_BYTES: begin
        if (l.fixed != 0) begin
          fval = {32'd0, cur + 32'd1};
          sval = l.fixed;
          skip = l.fixed;
          ph = PH_BYTES;
        end else ph = PH_VCNT;
      end
      default: ph = PH_BCNT;
    endcase
  endfunction

  function automatic void finish_index();
    logic [63:0] v;
    v = {{31{acc[32]}}, acc[32:0]};
    post(KIND_BLOCK, CLS_INDEX, v, 0, 0, 0, ERR_NONE);
  endfunction

  function automatic void take_byte(logic [7:0] b, logic [31:0] cur);
    int r;
    layout_t l;
    case (ph)
      PH_SUB: begin
        r = leb_take(b, 5, 0);
        if (r != LEB_MORE) begin
          cur_sub = acc[7:0];
          if (r == LEB_LONG) abort(ERR_OVERLONG);
          else begin
            l = layout_of(cur_op, acc[31:0]);
            if (!l.ok) abort(ERR_OPCODE);
            else start_imm(cur, l);
          end
        end
      end
      PH_U1: begin
        r = leb_take(b, 5, 0);
        if (r == LEB_LONG) abort(ERR_OVERLONG);
        else if (r == LEB_DONE) begin
          fval = {32'd0, acc[31:0]};
          l = layout_of(cur_op, {24'd0, cur_sub});
          if (l.kind == KIND_PAIR || l.kind == KIND_MEM) begin
            acc = 0;
            nbytes = 0;
            ph = PH_U2;
          end else if (l.rsv != 0) begin
            skip = l.rsv;
            ph = PH_RSV;
          end else post(KIND_U32, CLS_EMPTY, fval, 0, 0, 0, ERR_NONE);
        end
      end
      PH_U2: begin
        r = leb_take(b, 5, 0);
        if (r == LEB_LONG) abort(ERR_OVERLONG);
        else if (r == LEB_DONE) begin
          l = layout_of(cur_op, {24'd0, cur_sub});
          post(l.kind, CLS_EMPTY, fval, acc[31:0], 0, 0, ERR_NONE);
        end
      end
      PH_I32: begin
        r = leb_take(b, 5, 1);
        if (r == LEB_LONG) abort(ERR_OVERLONG);
        else if (r == LEB_DONE)
          post(KIND_I32, CLS_EMPTY, {{32{acc[31]}}, acc[31:0]}, 0, 0, 0, ERR_NONE);
      end
      PH_I64: begin
        r = leb_take(b, 10, 1);
        if (r == LEB_LONG) abort(ERR_OVERLONG);
        else if (r == LEB_DONE) post(KIND_I64, CLS_EMPTY, acc, 0, 0, 0, ERR_NONE);
      end
      PH_BLK: begin
        if (b == OP_EMPTY_BT) post(KIND_BLOCK, CLS_EMPTY, 0, 0, 0, 0, ERR_NONE);
        else if ((b >= 8'h7B && b <= VT_I32) || b == 8'h70 || b == VT_EXTERN)
          post(KIND_BLOCK, CLS_VALUE, {56'd0, b}, 0, 0, 0, ERR_NONE);
        else begin
          r = leb_take(b, 5, 1);
          if (r == LEB_DONE) finish_index();
          else ph = PH_S33;
        end
      end
      PH_S33: begin
        r = leb_take(b, 5, 1);
        if (r == LEB_LONG) abort(ERR_OVERLONG);
        else if (r == LEB_DONE) finish_index();
      end
      PH_RSV: begin
        if (b != 0) abort(ERR_RESERVED);
        else begin
          skip = skip - 1;
          if (skip == 0) begin
            l = layout_of(cur_op, {24'd0, cur_sub});
            post(l.kind, CLS_EMPTY, fval, 0, 0, 0, ERR_NONE);
          end
        end
      end
      PH_BYTES: begin
        skip = skip - 1;
        if (skip == 0) post(KIND_BYTES, CLS_EMPTY, 0, 0, fval[31:0], sval, ERR_NONE);
      end
      PH_VCNT: begin
        r = leb_take(b, 5, 0);
        if (r == LEB_LONG) abort(ERR_OVERLONG);
        else if (r == LEB_DONE) begin
          fval = {32'd0, cur + 32'd1};
          sval = acc[31:0];
          if (sval == 0) post(KIND_BYTES, CLS_EMPTY, 0, 0, fval[31:0], 0, ERR_NONE);
          else begin
            skip = sval;
            ph = PH_BYTES;
          end
        end
      end
      PH_BCNT: begin
        r = leb_take(b, 5, 0);
        if (r == LEB_LONG) abort(ERR_OVERLONG);
        else if (r == LEB_DONE) begin
          labels = acc[31:0];
          sval = (labels == 32'hFFFF_FFFF) ? labels : labels + 32'd1;
          fval = {32'd0, cur + 32'd1};
          acc = 0;
          nbytes = 0;
          ph = PH_BLAB;
        end
      end
      PH_BLAB: begin
        r = leb_take(b, 5, 0);
        if (r == LEB_LONG) abort(ERR_OVERLONG);
        else if (r == LEB_DONE) begin
          if (labels == 0) post(KIND_TABLE, CLS_EMPTY, 0, 0, fval[31:0], sval, ERR_NONE);
          else begin
            labels = labels - 1;
            acc = 0;
            nbytes = 0;
          end
        end
      end
      default: begin
        istart = cur;
        cur_op = b;
        cur_sub = 0;
        if (b == OP_MISC || b == OP_SIMD) begin
          acc = 0;
          nbytes = 0;
          ph = PH_SUB;
        end else begin
          l = layout_of(b, 0);
          if (!l.ok) abort(ERR_OPCODE);
          else start_imm(cur, l);
        end
      end
    endcase
  endfunction

  function automatic void cmp(string name, logic [63:0] want, logic [63:0] got);
    if (want !== got) begin
      $error("%s: expected %h, got %h", name, want, got);
      fails++;
    end
  endfunction

  always @(posedge clk) begin
    instr_t x;
    if (rst) begin
      ph = PH_IDLE;
      cur_op = 0;
      cur_sub = 0;
      acc = 0;
      nbytes = 0;
      fval = 0;
      sval = 0;
      skip = 0;
      labels = 0;
      offs = 0;
      istart = 0;
      decoded_q.delete();
      fails = 0;
    end else begin
      if (in_valid && !in_stall) begin
        if (restart) begin
          offs = 0;
          ph = PH_IDLE;
        end
        take_byte(code_byte, offs);
        offs = offs + 32'd1;
      end
      if (out_valid && !out_stall) begin
        if (decoded_q.size() == 0) begin
          $error("result with none expected: opcode %h at offset %h", opcode, start_offset);
          fails++;
        end else begin
          x = decoded_q.pop_front();
          cmp("opcode", x.opcode, opcode);
          cmp("subopcode", x.subopcode, subopcode);
          cmp("imm_kind", x.imm_kind, imm_kind);
          cmp("block_class", x.block_class, block_class);
          cmp("imm_first", x.imm_first, imm_first);
          cmp("imm_second", x.imm_second, imm_second);
          cmp("data_offset", x.data_offset, data_offset);
          cmp("data_length", x.data_length, data_length);
          cmp("start_offset", x.start_offset, start_offset);
          cmp("error", x.error, error);
        end
      end
    end
    pending = decoded_q.size();
  end
endmodule

// File: tb/wasm_instruction_decoder_unit_tb.sv
// Testbench top for the WebAssembly instruction decoder: feeds directed and random
// instruction streams with gaps and stalls, and reports the verdict.
// Depends on wid_pkg, wasm_instruction_decoder_unit and wid_checker.
module wasm_instruction_decoder_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import wid_pkg::*;

  logic        clk = 0;
  logic        rst = 1;
  logic        in_valid = 0;
  logic        in_stall;
  logic [7:0]  code_byte = 0;
  logic        restart = 0;
  logic        out_valid;
  logic        out_stall = 0;
  logic [7:0]  opcode;
  logic [7:0]  subopcode;
  logic [3:0]  imm_kind;
  logic [1:0]  block_class;
  logic signed [63:0] imm_first;
  logic [31:0] imm_second;
  logic [31:0] data_offset;
  logic [31:0] data_length;
  logic [31:0] start_offset;
  logic [1:0]  error;
  int          fails;
  int          pending;
  bit          calm = 0;
  bit          hog = 0;
  int          sent = 0;
  logic [7:0]  stream_q[$];

  always begin
    #1 clk = 1;
    #1 clk = 0;
  end

  wasm_instruction_decoder_unit dut (.*);
  wid_checker chk (.*);

  initial begin
    #400000;
    $display("wasm_instruction_decoder_unit: mismatch");
    $finish;
  end

  always begin
    int n;
    if (hog) begin
      out_stall <= 1;
      repeat (150) @(posedge clk);
      out_stall <= 0;
      hog = 0;
      @(posedge clk);
    end else if (calm || $urandom_range(0, 3) == 0) begin
      out_stall <= 0;
      n = $urandom_range(1, 16);
      repeat (n) @(posedge clk);
    end else begin
      out_stall <= 1;
      n = $urandom_range(1, 16);
      repeat (n) @(posedge clk);
      out_stall <= 0;
      @(posedge clk);
    end
  end

  task automatic send(logic [7:0] b, bit rs);
    in_valid <= 1;
    code_byte <= b;
    restart <= rs;
    @(negedge clk);
    while (in_stall) @(negedge clk);
    @(posedge clk);
    sent++;
  endtask

  task automatic flush(bit gaps);
    int n;
    while (stream_q.size() != 0) begin
      if (gaps && !calm && $urandom_range(0, 7) == 0) begin
        in_valid <= 0;
        n = $urandom_range(1, 16);
        repeat (n) @(posedge clk);
      end
      send(stream_q.pop_front(), gaps && $urandom_range(0, 59) == 0);
    end
  endtask

  task automatic drain();
    in_valid <= 0;
    @(negedge clk);
    while (pending != 0) @(negedge clk);
    @(posedge clk);
  endtask

  function automatic void put_leb(logic [63:0] v, int n, bit overlong);
    for (int i = 0; i < n; i++)
      stream_q.push_back({(i < n - 1) || overlong, 7'((v >> (7 * i)) & 64'h7F)});
  endfunction

  function automatic logic [63:0] rnd64();
    return {$urandom, $urandom} >> $urandom_range(0, 63);
  endfunction

  function automatic void put_var(int maxb, bit sgn);
    int n;
    logic [63:0] v;
    v = rnd64();
    if (sgn && $urandom_range(0, 1)) v = -v;
    n = $urandom_range(1, maxb);
    put_leb(v, n, $urandom_range(0, 24) == 0);
  endfunction

  function automatic void put_raw(int n);
    for (int i = 0; i < n; i++) stream_q.push_back(8'($urandom));
  endfunction

  function automatic void gen_instr();
    logic [7:0] op;
    int sub;
    int n;
    case ($urandom_range(0, 15))
      0: stream_q.push_back(8'($urandom));
      1, 2: stream_q.push_back(8'($urandom_range(8'h45, 8'hC4)));
      3: begin
        stream_q.push_back(8'($urandom_range(8'h20, 8'h26)));
        put_var(5, 0);
      end
      4: begin
        stream_q.push_back(8'($urandom_range(8'h28, 8'h3E)));
        put_var(5, 0);
        put_var(5, 0);
      end
      5: begin
        stream_q.push_back(OP_CALL_IND);
        put_var(5, 0);
        put_var(5, 0);
      end
      6: begin
        stream_q.push_back(8'h41);
        put_var(5, 1);
      end
      7: begin
        stream_q.push_back(8'h42);
        put_var(10, 1);
      end
      8: begin
        stream_q.push_back(8'($urandom_range(OP_BLK_LO, 8'h04)));
        case ($urandom_range(0, 3))
          0: stream_q.push_back(OP_EMPTY_BT);
          1: stream_q.push_back(8'($urandom_range(8'h6F, 8'h7F)));
          default: put_var(5, 1);
        endcase
      end
      9: begin
        stream_q.push_back($urandom_range(0, 1) ? OP_F32 : OP_F64);
        put_raw(8);
      end
      10: begin
        stream_q.push_back(OP_SEL_TYPED);
        n = $urandom_range(0, 3);
        put_leb(n, $urandom_range(1, 2), 0);
        put_raw(n);
      end
      11: begin
        stream_q.push_back(OP_JUMP_TBL);
        n = $urandom_range(0, 4);
        put_leb(n, $urandom_range(1, 3), 0);
        for (int i = 0; i <= n; i++) put_var(5, 0);
      end
      12: begin
        stream_q.push_back($urandom_range(0, 1) ? 8'h3F : 8'h40);
        stream_q.push_back($urandom_range(0, 5) == 0 ? 8'($urandom) : 8'h00);
      end
      13: begin
        stream_q.push_back(OP_MISC);
        sub = $urandom_range(0, 19);
        put_leb(sub, $urandom_range(1, 2), 0);
        if (sub >= 8 && sub <= 17 && sub != 10 && sub != 11) put_var(5, 0);
        if (sub == 12 || sub == 14) put_var(5, 0);
        if (sub == 8 || sub == 10 || sub == 11) stream_q.push_back(8'h00);
        if (sub == 10) stream_q.push_back($urandom_range(0, 7) == 0 ? 8'h01 : 8'h00);
      end
      default: begin
        stream_q.push_back(OP_SIMD);
        sub = $urandom_range(0, 20) == 0 ? $urandom_range(256, 1000) : $urandom_range(0, 255);
        put_leb(sub, $urandom_range(1, 3), 0);
        if (sub <= 11 || (sub >= 84 && sub <= 93)) begin
          put_var(5, 0);
          put_var(5, 0);
        end else if (sub == 12 || sub == 13) put_raw(16);
        else if (sub >= 21 && sub <= 34) put_var(5, 0);
      end
    endcase
  endfunction

  task automatic run_random(int count, bit gaps);
    int stop;
    stop = sent + count;
    while (sent < stop) begin
      gen_instr();
      flush(gaps);
    end
  endtask

  initial begin
    repeat (7) @(posedge clk);
    rst <= 0;
    @(posedge clk);
    stream_q = '{8'h00, 8'hFF, 8'h41, 8'h80, 8'h80, 8'h80, 8'h80, 8'h80,
                 8'h02, 8'h40, 8'h03, 8'h6F, 8'h04, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'h0F,
                 8'h3F, 8'h01, 8'hFC, 8'h80, 8'h02, 8'hFD, 8'hFF, 8'h01,
                 8'h0E, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'h0F, 8'h01, 8'h02};
    flush(0);
    send(8'h01, 1);
    stream_q = '{8'h42, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF,
                 8'h7F, 8'hFC, 8'h0A, 8'h00, 8'h00, 8'hFC, 8'h08, 8'h85, 8'h00, 8'h00};
    flush(0);
    run_random(600, 1);
    hog = 1;
    run_random(200, 0);
    drain();
    run_random(700, 1);
    calm = 1;
    run_random(200, 0);
    drain();
    repeat (10) @(posedge clk);
    if (fails == 0) $display("wasm_instruction_decoder_unit: match");
    else $display("wasm_instruction_decoder_unit: mismatch");
    $finish;
  end
endmodule
